@@ src/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants and types for the double-ended queue: command and status
// codes, default depth and the control word that drives a row of cells.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned DefCntW  = $clog2(DefDepth + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned StatusW  = 2;

  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLEAR      = 3'd4;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_PUSH_FULL = 2'd2;

  // one row keeps its own end of the queue at cell 0
  typedef struct packed {
    logic push_head;  // shift away from cell 0, new value enters cell 0
    logic pop_head;   // shift toward cell 0
    logic push_tail;  // write the value into the first free cell
  } row_ctrl_t;

endpackage

@@ src/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_cmd_if / deq_res_if
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface deq_cmd_if
  import deq_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic signed [DataW-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface deq_res_if
  import deq_pkg::*;
#(
  parameter int unsigned CntW = DefCntW
);
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] popped_value;
  logic signed [DataW-1:0] front_value;
  logic signed [DataW-1:0] rear_value;
  logic [CntW-1:0]         entry_count;
  logic                    is_empty;
  logic                    is_full;
  logic [StatusW-1:0]      status;

  modport source (
    output valid, output popped_value, output front_value, output rear_value,
    output entry_count, output is_empty, output is_full, output status,
    input ready
  );
  modport sink (
    input valid, input popped_value, input front_value, input rear_value,
    input entry_count, input is_empty, input is_full, input status,
    output ready
  );
endinterface

@@ src/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of a row: holds an entry and takes its next value from
// the neighbor toward cell 0, the neighbor away from it, or the push value.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  row_ctrl_t               ctrl_i,
  input  logic                    sel_i,
  input  logic signed [DataW-1:0] prev_i,
  input  logic signed [DataW-1:0] next_i,
  input  logic signed [DataW-1:0] value_i,
  output logic signed [DataW-1:0] data_o
);

  logic signed [DataW-1:0] data_q;
  logic signed [DataW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.push_head) begin
      data_d = prev_i;
    end else if (ctrl_i.pop_head) begin
      data_d = next_i;
    end else if (ctrl_i.push_tail && sel_i) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ src/deq_row.sv @@
// ----------------------------------------------------------------------------
// deq_row
// A chain of DEPTH cells holding the queue in order from cell 0. Pushes and
// pops at cell 0 shift the whole chain; a push at the far end writes the
// cell whose index equals the current count.
// ----------------------------------------------------------------------------
module deq_row
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  row_ctrl_t               ctrl_i,
  input  logic [CntW-1:0]         count_i,
  input  logic signed [DataW-1:0] value_i,
  output logic signed [DataW-1:0] head_o,
  output logic signed [DataW-1:0] second_o
);

  logic signed [DataW-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] prev;
    logic signed [DataW-1:0] next;

    if (i == 0) begin : g_first
      assign prev = value_i;
    end else begin : g_mid
      assign prev = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = data[i];
    end else begin : g_inner
      assign next = data[i+1];
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .sel_i   (count_i == CntW'(i)),
      .prev_i  (prev),
      .next_i  (next),
      .value_i (value_i),
      .data_o  (data[i])
    );
  end

  assign head_o   = data[0];
  assign second_o = data[1];

endmodule

@@ src/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values. A command (push front, push back,
// pop front, pop back, clear) is taken and its result appears in the output
// register on the next cycle; a new command is taken in every cycle that the
// result register is empty or being emptied, so the sustained rate is one
// command per cycle, set by the in-place update of both cell rows. The queue
// is held twice, in two chains of DEPTH cells: one keeps the front entry in
// its cell 0, the other keeps the rear entry in its cell 0, so front, rear
// and popped values come from fixed cells, the push value or 0. A pop from
// an empty queue returns 0 with status 1; a push to a full queue is dropped
// with status 2. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  deq_cmd_if.sink     cmd_i,
  deq_res_if.source   res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  logic                    out_valid_q;
  logic signed [DataW-1:0] popped_q;
  logic signed [DataW-1:0] front_q;
  logic signed [DataW-1:0] rear_q;
  logic [CntW-1:0]         out_count_q;
  logic [StatusW-1:0]      status_q;

  logic                    accept;
  logic                    is_empty;
  logic                    is_full;
  logic signed [DataW-1:0] fwd_head;
  logic signed [DataW-1:0] fwd_second;
  logic signed [DataW-1:0] bwd_head;
  logic signed [DataW-1:0] bwd_second;

  logic                    push_front_ok;
  logic                    push_back_ok;
  logic                    pop_front_ok;
  logic                    pop_back_ok;
  logic signed [DataW-1:0] popped_d;
  logic signed [DataW-1:0] front_d;
  logic signed [DataW-1:0] rear_d;
  logic [StatusW-1:0]      status_d;
  row_ctrl_t               fwd_ctrl;
  row_ctrl_t               bwd_ctrl;

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CntW'(DEPTH));

  assign push_front_ok = accept && (cmd_i.cmd == CMD_PUSH_FRONT) && !is_full;
  assign push_back_ok  = accept && (cmd_i.cmd == CMD_PUSH_BACK) && !is_full;
  assign pop_front_ok  = accept && (cmd_i.cmd == CMD_POP_FRONT) && !is_empty;
  assign pop_back_ok   = accept && (cmd_i.cmd == CMD_POP_BACK) && !is_empty;

  // front-ordered row and rear-ordered row mirror each other
  assign fwd_ctrl = '{push_head: push_front_ok, pop_head: pop_front_ok,
                      push_tail: push_back_ok};
  assign bwd_ctrl = '{push_head: push_back_ok, pop_head: pop_back_ok,
                      push_tail: push_front_ok};

  deq_row #(.DEPTH(DEPTH), .CntW(CntW)) u_fwd_row (
    .clk_i    (clk_i),
    .ctrl_i   (fwd_ctrl),
    .count_i  (count_q),
    .value_i  (cmd_i.push_value),
    .head_o   (fwd_head),
    .second_o (fwd_second)
  );

  deq_row #(.DEPTH(DEPTH), .CntW(CntW)) u_bwd_row (
    .clk_i    (clk_i),
    .ctrl_i   (bwd_ctrl),
    .count_i  (count_q),
    .value_i  (cmd_i.push_value),
    .head_o   (bwd_head),
    .second_o (bwd_second)
  );

  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = ST_OK;
    front_d  = fwd_head;
    rear_d   = bwd_head;
    case (cmd_i.cmd)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          count_d = count_q + 1'b1;
          front_d = cmd_i.push_value;
          if (is_empty) begin
            rear_d = cmd_i.push_value;
          end
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          count_d = count_q + 1'b1;
          rear_d  = cmd_i.push_value;
          if (is_empty) begin
            front_d = cmd_i.push_value;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          count_d  = count_q - 1'b1;
          popped_d = fwd_head;
          front_d  = fwd_second;
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          count_d  = count_q - 1'b1;
          popped_d = bwd_head;
          rear_d   = bwd_second;
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (count_d == '0) begin
      front_d = '0;
      rear_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q    <= popped_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      out_count_q <= count_d;
      status_q    <= status_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.popped_value = popped_q;
  assign res_o.front_value  = front_q;
  assign res_o.rear_value   = rear_q;
  assign res_o.entry_count  = out_count_q;
  assign res_o.is_empty     = (out_count_q == '0);
  assign res_o.is_full      = (out_count_q == CntW'(DEPTH));
  assign res_o.status       = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  a_single_entry_rows_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntW'(1)) |-> (fwd_head == bwd_head))
    else $error("front and rear rows disagree on the only entry");

  a_push_front_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_front_ok |=> (fwd_head == $past(cmd_i.push_value)))
    else $error("pushed front value not at head of front row");

  a_full_status_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == ST_PUSH_FULL)) |-> res_o.is_full)
    else $error("dropped push reported without full flag");

  a_count_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_count_q == count_q))
    else $error("reported count differs from stored count");

endmodule

@@ tb/double_ended_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque. Every accepted command request
// updates a mirror of the ring (front pointer, fill level, stored values) and
// queues the result the block has to answer with; every accepted result is
// compared field by field against the oldest queued one. Both channels idle
// at random, and the sender pauses now and then until the results catch up.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [deq_pkg::DataW-1:0]   popped;
  logic signed [deq_pkg::DataW-1:0]   front;
  logic signed [deq_pkg::DataW-1:0]   rear;
  logic [deq_pkg::DefCntW-1:0]        count;
  logic                               empty;
  logic                               full;
  logic [deq_pkg::StatusW-1:0]        status;
} deq_result_t;

class deque_tracker;
  localparam int unsigned Slots = deq_pkg::DefDepth;

  logic [deq_pkg::DataW-1:0] ring [Slots];
  int unsigned               front_ptr = 0;
  int unsigned               fill = 0;
  deq_result_t               awaited [$];
  int unsigned               error_count = 0;

  // applies one accepted request to the mirror and queues its result
  function void note_command(logic [deq_pkg::CmdW-1:0] op,
                             logic [deq_pkg::DataW-1:0] value);
    deq_result_t r;
    r = '0;
    r.status = deq_pkg::ST_OK;
    case (op)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (fill == Slots) begin
          r.status = deq_pkg::ST_PUSH_FULL;
        end else if (op == deq_pkg::CMD_PUSH_FRONT) begin
          front_ptr = (front_ptr + Slots - 1) % Slots;
          ring[front_ptr] = value;
          fill++;
        end else begin
          ring[(front_ptr + fill) % Slots] = value;
          fill++;
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (fill == 0) begin
          r.status = deq_pkg::ST_POP_EMPTY;
        end else if (op == deq_pkg::CMD_POP_FRONT) begin
          r.popped = ring[front_ptr];
          front_ptr = (front_ptr + 1) % Slots;
          fill--;
        end else begin
          r.popped = ring[(front_ptr + fill - 1) % Slots];
          fill--;
        end
      end
      deq_pkg::CMD_CLEAR: begin
        front_ptr = 0;
        fill = 0;
      end
      default: begin
      end
    endcase
    if (fill != 0) begin
      r.front = ring[front_ptr];
      r.rear  = ring[(front_ptr + fill - 1) % Slots];
    end
    r.count = fill[deq_pkg::DefCntW-1:0];
    r.empty = (fill == 0);
    r.full  = (fill == Slots);
    awaited.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function void check_result(deq_result_t got);
    deq_result_t want;
    if (awaited.size() == 0) begin
      $display("%0t: result with nothing expected, actual %p", $time, got);
      error_count++;
      return;
    end
    want = awaited.pop_front();
    compare_field("popped_value", want.popped, got.popped);
    compare_field("front_value", want.front, got.front);
    compare_field("rear_value", want.rear, got.rear);
    compare_field("entry_count", 32'(want.count), 32'(got.count));
    compare_field("is_empty", 32'(want.empty), 32'(got.empty));
    compare_field("is_full", 32'(want.full), 32'(got.full));
    compare_field("status", 32'(want.status), 32'(got.status));
  endfunction
endclass

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned QDepth = DefDepth;
  localparam int unsigned StallLimit = 1000;
  localparam logic [CmdW-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_UNUSED_LAST  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_cmd_if cmd_bus ();
  deq_res_if #(.CntW(DefCntW)) res_bus ();

  double_ended_queue #(
    .DEPTH(QDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  deque_tracker tracker;
  logic         tx_calm = 1'b0;
  int unsigned  quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  // watchdog: too long without any handshake on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("double_ended_queue_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_cmd(logic [CmdW-1:0] op, logic [DataW-1:0] value);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= op;
    cmd_bus.push_value <= value;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    tracker.note_command(op, value);
  endtask

  // drop the request line and hold off until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic collect_results();
    deq_result_t got;
    int unsigned stall;
    int unsigned seen;
    logic        rx_calm;
    seen = 0;
    rx_calm = 1'b0;
    forever begin
      if (seen % 30 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 8);
      @(negedge clk_i);
      if (stall != 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_bus.valid) @(posedge clk_i);
      got.popped = res_bus.popped_value;
      got.front  = res_bus.front_value;
      got.rear   = res_bus.rear_value;
      got.count  = res_bus.entry_count;
      got.empty  = res_bus.is_empty;
      got.full   = res_bus.is_full;
      got.status = res_bus.status;
      tracker.check_result(got);
      seen++;
    end
  endtask

  // extremes show up often, the rest is plain random
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // lean 0 fills the queue, lean 1 drains it, lean 2 stays balanced
  function automatic logic [CmdW-1:0] pick_cmd(int unsigned lean);
    int unsigned roll;
    int unsigned push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (lean == 0) ? 70 : (lean == 1) ? 25 : 48;
    if (roll < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (roll < 95) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    if (roll < 97) return CMD_CLEAR;
    return CmdW'(CMD_UNUSED_FIRST + $urandom_range(0, CMD_UNUSED_LAST - CMD_UNUSED_FIRST));
  endfunction

  initial begin
    rst_ni             = 1'b0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.cmd        = CMD_PUSH_FRONT;
    cmd_bus.push_value = '0;
    res_bus.ready      = 1'b0;
    tracker = new();
    fork
      collect_results();
    join_none
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // pops on an empty queue, extremes, a spare code, then fill past full
    send_cmd(CMD_POP_FRONT, 32'h1234_5678);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff);
    send_cmd(CMD_UNUSED_FIRST, 32'hffff_ffff);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    for (int i = 0; i < QDepth; i++) begin
      send_cmd((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
    end
    send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    send_cmd(CMD_UNUSED_LAST, 32'h0);
    send_cmd(CMD_CLEAR, 32'h0);
    wait_drained();

    for (int blk = 0; blk < 14; blk++) begin
      int unsigned lean;
      lean = $urandom_range(0, 2);
      tx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 40; i++) begin
        send_cmd(pick_cmd(lean), pick_value());
      end
      if (blk % 5 == 4) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.error_count == 0 && tracker.awaited.size() == 0) begin
      $display("double_ended_queue_tb OK");
    end else begin
      $display("double_ended_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/deq_pkg.sv
src/deq_if.sv
src/deq_cell.sv
src/deq_row.sv
src/double_ended_queue.sv
tb/double_ended_queue_tb.sv
